// File: rtl/core/gab_pkg.sv
// Package for the glyph alpha blitter: function codes, status codes,
// register indexes and the glyph table entry type. No dependencies.
package gab_pkg;

    localparam int FUNC_W = 3;
    localparam logic [2:0] FN_LOAD_GLYPH = 3'd0;
    localparam logic [2:0] FN_LOAD_COV   = 3'd1;
    localparam logic [2:0] FN_WRITE_PIX  = 3'd2;
    localparam logic [2:0] FN_READ_PIX   = 3'd3;
    localparam logic [2:0] FN_DRAW       = 3'd4;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NO_GLYPH = 2'd1;
    localparam logic [1:0] ST_BAD_SLOT = 2'd2;

    localparam logic [2:0] REG_FIRST_CODE = 3'd0;
    localparam logic [2:0] REG_GLYPH_CNT  = 3'd1;
    localparam logic [2:0] REG_ASCENT     = 3'd2;
    localparam logic [2:0] REG_SURF_W     = 3'd3;
    localparam logic [2:0] REG_SURF_H     = 3'd4;
    localparam logic [2:0] REG_STRIDE     = 3'd5;

    localparam logic [7:0] FULL_COVER = 8'hFF;
    localparam logic [7:0] OPAQUE     = 8'hFF;
    localparam int IN_W  = 160;
    localparam int OUT_W = 56;

    typedef struct packed {
        logic signed [7:0] x0;
        logic signed [7:0] y0;
        logic [6:0]        width;
        logic [6:0]        height;
        logic [7:0]        advance;
        logic [13:0]       offset;
    } glyph_t;

    // Per-channel blend: (fg*a + bg*(255-a)) >> 8
    function automatic logic [7:0] blend_ch(input logic [7:0] fg, input logic [7:0] bg,
                                            input logic [7:0] a);
        logic [16:0] s;
        s = 17'(fg * a) + 17'(bg * (8'd255 - a));
        return s[15:8];
    endfunction

endpackage

// File: rtl/core/glyph_alpha_blitter.sv
// Glyph alpha blitter top level: glyph table, coverage store, frame store and
// the draw sequencer. Depends on gab_pkg.
//
// Load and write items go straight to the result; read items read the frame store first.
// Draw reads the glyph entry, then per coverage byte reads it and, if nonzero and on the
// surface, reads the frame word and writes it; a code point outside the font goes straight
// to the result. One item at a time; the next request is taken once the result is accepted.
// Reset (aresetn, synchronous, low) clears control state and the registers to
// their defaults; memories are not cleared.
module glyph_alpha_blitter #(
    parameter int GLYPH_SLOTS    = 128,
    parameter int COVERAGE_BYTES = 16384,
    parameter int FRAME_WORDS    = 65536,
    parameter int MAX_GLYPH_SIDE = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // slot[15:0], pos_x[31:16], pos_y[47:32], code_point[68:48],
    // data_word[100:69], glyph_x0[108:101], glyph_y0[116:109], glyph_width[123:117],
    // glyph_height[130:124], glyph_advance[138:131], glyph_offset[152:139], zeros above
    input  logic [gab_pkg::IN_W-1:0] s_tdata,
    // func[2:0]
    input  logic [gab_pkg::FUNC_W-1:0] s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_pixel[31:0], advance[39:32], status[41:40], pixels_written[54:42], zero[55]
    output logic [gab_pkg::OUT_W-1:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import gab_pkg::*;

    localparam int GA = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
    localparam int CA = $clog2(COVERAGE_BYTES);
    localparam int FA = $clog2(FRAME_WORDS);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_GLYPH = 8'b00000010,
        S_SETUP = 8'b00000100,
        S_CREAD = 8'b00001000,
        S_CWAIT = 8'b00010000,
        S_FWAIT = 8'b00100000,
        S_FWRITE= 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    // Field unpack
    logic [2:0]  in_func;
    logic [15:0] in_slot;
    logic signed [15:0] in_x, in_y;
    logic [20:0] in_cp;
    logic [31:0] in_data;
    glyph_t      in_glyph;
    logic [6:0]  in_w, in_h;
    assign in_func = s_tuser;
    assign in_slot = s_tdata[15:0];
    assign in_x    = s_tdata[31:16];
    assign in_y    = s_tdata[47:32];
    assign in_cp   = s_tdata[68:48];
    assign in_data = s_tdata[100:69];
    assign in_w    = s_tdata[123:117];
    assign in_h    = s_tdata[130:124];
    always_comb begin
        in_glyph.x0      = s_tdata[108:101];
        in_glyph.y0      = s_tdata[116:109];
        in_glyph.width   = (in_w > 7'(MAX_GLYPH_SIDE)) ? 7'(MAX_GLYPH_SIDE) : in_w;
        in_glyph.height  = (in_h > 7'(MAX_GLYPH_SIDE)) ? 7'(MAX_GLYPH_SIDE) : in_h;
        in_glyph.advance = s_tdata[138:131];
        in_glyph.offset  = s_tdata[152:139];
    end

    // Configuration registers
    logic [20:0] first_code_reg;
    logic [7:0]  glyph_count_reg;
    logic [6:0]  ascent_reg;
    logic [12:0] surf_w_reg, surf_h_reg, stride_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_code_reg  <= 21'd32;
            glyph_count_reg <= 8'd95;
            ascent_reg      <= 7'd0;
            surf_w_reg      <= 13'd256;
            surf_h_reg      <= 13'd256;
            stride_reg      <= 13'd256;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FIRST_CODE: first_code_reg  <= cfg_data[20:0];
                REG_GLYPH_CNT:  glyph_count_reg <= cfg_data[7:0];
                REG_ASCENT:     ascent_reg      <= cfg_data[6:0];
                REG_SURF_W:     surf_w_reg      <= cfg_data[12:0];
                REG_SURF_H:     surf_h_reg      <= cfg_data[12:0];
                REG_STRIDE:     stride_reg      <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Memories
    glyph_t      gtab [GLYPH_SLOTS];
    logic [7:0]  cstore [COVERAGE_BYTES];
    logic [31:0] fstore [FRAME_WORDS];
    logic [GA-1:0] g_raddr;
    glyph_t      g_rd;
    logic          g_we;
    logic [CA-1:0] c_addr;
    logic          c_we;
    logic [7:0]    c_rd;
    logic [FA-1:0] f_addr;
    logic          f_we;
    logic [31:0]   f_wdata, f_rd;

    always_ff @(posedge aclk) begin
        if (g_we) gtab[in_slot[GA-1:0]] <= in_glyph;
        g_rd <= gtab[g_raddr];
    end
    always_ff @(posedge aclk) begin
        if (c_we) cstore[c_addr] <= in_data[7:0];
        c_rd <= cstore[c_addr];
    end
    always_ff @(posedge aclk) begin
        if (f_we) fstore[f_addr] <= f_wdata;
        f_rd <= fstore[f_addr];
    end

    // Control registers
    state_t state_reg;
    logic [2:0]  func_reg;
    logic [31:0] data_reg;
    logic [20:0] gidx_reg;
    logic signed [17:0] sx_reg, sy_reg;
    glyph_t      gl_reg;
    logic [6:0]  gx_reg, gy_reg;
    logic [20:0] caddr_reg;
    logic signed [19:0] px_reg, py_reg;
    logic [25:0] faddr_reg;
    logic [7:0]  a_reg;
    logic [31:0] rd_reg;
    logic [7:0]  adv_reg;
    logic [1:0]  st_reg;
    logic [12:0] wr_reg;

    logic in_acc;
    logic [20:0] cp_diff;
    logic        cp_miss;
    logic        slot_ok;
    logic        last_x, last_y, pix_ok;
    logic [25:0] faddr_calc;

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {1'b0, wr_reg, st_reg, adv_reg, rd_reg};

    assign cp_diff = in_cp - first_code_reg;
    assign cp_miss = (in_cp < first_code_reg) || (cp_diff >= 21'(glyph_count_reg))
                     || (cp_diff >= 21'(GLYPH_SLOTS));
    always_comb begin
        case (in_func)
            FN_LOAD_GLYPH: slot_ok = 32'(in_slot) < GLYPH_SLOTS;
            FN_LOAD_COV:   slot_ok = 32'(in_slot) < COVERAGE_BYTES;
            default:       slot_ok = 32'(in_slot) < FRAME_WORDS;
        endcase
    end

    assign last_x = (gx_reg + 7'd1 >= gl_reg.width);
    assign last_y = (gy_reg + 7'd1 >= gl_reg.height);
    assign pix_ok = !px_reg[19] && !py_reg[19] && (px_reg < 20'(surf_w_reg))
                    && (py_reg < 20'(surf_h_reg));
    assign faddr_calc = 26'(py_reg[12:0] * stride_reg) + 26'(px_reg[12:0]);

    // Memory port steering
    always_comb begin
        g_raddr = gidx_reg[GA-1:0];
        g_we    = in_acc && in_func == FN_LOAD_GLYPH && slot_ok;
        c_we    = in_acc && in_func == FN_LOAD_COV && slot_ok;
        c_addr  = (state_reg == S_IDLE) ? CA'(in_slot) : caddr_reg[CA-1:0];
        f_we    = 1'b0;
        f_addr  = faddr_reg[FA-1:0];
        f_wdata = data_reg;
        if (state_reg == S_IDLE) begin
            f_addr = FA'(in_slot);
            f_we   = in_acc && in_func == FN_WRITE_PIX && slot_ok;
            f_wdata = in_data;
        end else if (state_reg == S_FWRITE) begin
            f_we = (func_reg == FN_DRAW);
            if (a_reg != FULL_COVER)
                f_wdata = {OPAQUE, blend_ch(data_reg[23:16], f_rd[23:16], a_reg),
                           blend_ch(data_reg[15:8], f_rd[15:8], a_reg),
                           blend_ch(data_reg[7:0], f_rd[7:0], a_reg)};
        end
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: if (in_acc) begin
                    func_reg <= in_func;
                    data_reg <= in_data;
                    gidx_reg <= cp_diff;
                    faddr_reg <= 26'(in_slot);
                    rd_reg <= 32'd0; adv_reg <= 8'd0; wr_reg <= 13'd0;
                    if (in_func == FN_DRAW) begin
                        sx_reg <= 18'(in_x);
                        sy_reg <= 18'(in_y) + 18'(ascent_reg);
                        st_reg <= cp_miss ? ST_NO_GLYPH : ST_DONE;
                        state_reg <= cp_miss ? S_OUT : S_GLYPH;
                    end else if (in_func > FN_DRAW) begin
                        st_reg <= ST_DONE;
                        state_reg <= S_OUT;
                    end else begin
                        st_reg <= slot_ok ? ST_DONE : ST_BAD_SLOT;
                        state_reg <= (in_func == FN_READ_PIX && slot_ok) ? S_FWAIT : S_OUT;
                    end
                end
                S_GLYPH: state_reg <= S_SETUP;
                S_SETUP: begin
                    gl_reg <= g_rd;
                    adv_reg <= g_rd.advance;
                    sx_reg <= sx_reg + 18'(g_rd.x0);
                    sy_reg <= sy_reg + 18'(g_rd.y0);
                    gx_reg <= 7'd0; gy_reg <= 7'd0;
                    caddr_reg <= 21'(g_rd.offset);
                    state_reg <= (g_rd.width == 7'd0 || g_rd.height == 7'd0) ? S_OUT : S_CREAD;
                end
                S_CREAD: begin
                    px_reg <= 20'(sx_reg) + 20'(gx_reg);
                    py_reg <= 20'(sy_reg) + 20'(gy_reg);
                    state_reg <= S_CWAIT;
                end
                S_CWAIT: begin
                    a_reg <= c_rd;
                    faddr_reg <= faddr_calc;
                    if (caddr_reg < 21'(COVERAGE_BYTES) && c_rd != 8'd0 && pix_ok
                        && faddr_calc < 26'(FRAME_WORDS)) begin
                        state_reg <= S_FWAIT;
                    end else begin
                        caddr_reg <= caddr_reg + 21'd1;
                        gx_reg <= last_x ? 7'd0 : gx_reg + 7'd1;
                        if (last_x) gy_reg <= gy_reg + 7'd1;
                        state_reg <= (last_x && last_y) ? S_OUT : S_CREAD;
                    end
                end
                S_FWAIT: state_reg <= S_FWRITE;
                S_FWRITE: begin
                    if (func_reg == FN_READ_PIX) begin
                        rd_reg <= f_rd;
                        state_reg <= S_OUT;
                    end else begin
                        if (wr_reg != 13'h1FFF) wr_reg <= wr_reg + 13'd1;
                        caddr_reg <= caddr_reg + 21'd1;
                        gx_reg <= last_x ? 7'd0 : gx_reg + 7'd1;
                        if (last_x) gy_reg <= gy_reg + 7'd1;
                        state_reg <= (last_x && last_y) ? S_OUT : S_CREAD;
                    end
                end
                S_OUT: if (m_tready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Checks
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input and output open together");
    a_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st_reg != ST_DONE |-> wr_reg == 13'd0)
        else $error("pixels written on a failed item");
    a_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && func_reg != FN_READ_PIX |-> rd_reg == 32'd0)
        else $error("read data on a non-read item");
endmodule
